[hw/rtl/rlnp_pkg.sv]
// ----------------------------------------------------------------------------
// rlnp_pkg
// shared types, constants and codes for the reified linear not-equal propagator
// ----------------------------------------------------------------------------
package rlnp_pkg;

  localparam int unsigned MaxVarsDef    = 256;
  localparam int unsigned TrailDepthDef = 64;
  localparam int unsigned CoeffBitsDef  = 16;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ADD    = 3'd1,
    OP_INST   = 3'd2,
    OP_MIN    = 3'd3,
    OP_MAX    = 3'd4,
    OP_ASSIGN = 3'd5,
    OP_REWIND = 3'd6,
    OP_NONE   = 3'd7
  } op_e;

  localparam logic [1:0] BFalse = 2'd1;
  localparam logic [1:0] BTrue  = 2'd2;

  localparam logic [1:0] InferNone  = 2'd0;
  localparam logic [1:0] InferTrue  = 2'd1;
  localparam logic [1:0] InferFalse = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         var_index;
    logic [1:0]         b_status;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic [15:0]        search_level;
  } in_word_t;

  typedef struct packed {
    logic       conflict;
    logic [1:0] infer_b;
    logic       trail_overflow;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;     // latch input word
    logic exec;        // apply update (with coefficient ready)
    logic pop_rd;      // issue read of trail top
    logic pop_apply;   // restore state from trail top
    logic emit;        // form result word
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic       is_rewind;
    logic       pop_more;
  } stat_t;

endpackage

[hw/rtl/rlnp_ram.sv]
// ----------------------------------------------------------------------------
// rlnp_ram
// generic single-port-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rlnp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/rlnp_datapath.sv]
// ----------------------------------------------------------------------------
// rlnp_datapath
// coefficient table, running sums, trail stack and bounds check
// ----------------------------------------------------------------------------
module rlnp_datapath import rlnp_pkg::*; #(
  parameter int unsigned MaxVars    = MaxVarsDef,
  parameter int unsigned TrailDepth = TrailDepthDef,
  parameter int unsigned CoeffBits  = CoeffBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [31:0] cfg_wdata_i,
  input  in_word_t           in_i,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  output out_word_t          res_o
);

  localparam int unsigned VarAw  = $clog2(MaxVars);
  localparam int unsigned TrAw   = $clog2(TrailDepth);
  localparam int unsigned CntW   = $clog2(MaxVars + 1);
  localparam int unsigned TopW   = $clog2(TrailDepth + 1);
  localparam int unsigned TrW    = 16 + 3 * 64 + CntW;

  logic signed [31:0] target_q;
  in_word_t           w_q;
  logic [63:0]        fixed_q, minp_q, maxp_q;
  logic [CntW-1:0]    cnt_q;
  logic [TopW-1:0]    top_q;
  logic [15:0]        top_level_q;   // level of the top trail entry
  logic [15:0]        pop_level_q;
  logic               ovf_q;

  // index range
  logic ok;
  logic [VarAw-1:0] idx;
  always_comb begin
    ok  = ({24'd0, w_q.var_index} < 32'(MaxVars));
    idx = VarAw'(w_q.var_index);
  end

  // coefficient table
  logic [CoeffBits-1:0] coeff_rd;
  logic                 coeff_we;
  logic [VarAw-1:0]     coeff_idx;
  always_comb begin
    coeff_we  = ctrl_i.exec && (w_q.operation == OP_ADD) && ok;
    coeff_idx = ctrl_i.capture ? VarAw'(in_i.var_index) : idx;
  end
  rlnp_ram #(.Width(CoeffBits), .Depth(MaxVars)) u_coeff (
    .clk_i, .we_i(coeff_we), .waddr_i(idx),
    .wdata_i(w_q.value_c[CoeffBits-1:0]),
    .raddr_i(coeff_idx), .rdata_o(coeff_rd)
  );

  // trail memory
  logic           tr_we;
  logic [TrW-1:0] tr_wdata, tr_rdata;
  logic [TrAw-1:0] tr_waddr, tr_raddr;
  logic           push_req, push_skip, push_full;
  always_comb begin
    push_req  = ctrl_i.exec && ok &&
                (w_q.operation == OP_INST || w_q.operation == OP_MIN ||
                 w_q.operation == OP_MAX);
    push_skip = (top_q != '0) && (top_level_q == w_q.search_level);
    push_full = (top_q == TopW'(TrailDepth));
    tr_we     = push_req && !push_skip && !push_full;
    tr_waddr  = TrAw'(top_q);
    tr_wdata  = {w_q.search_level, fixed_q, minp_q, maxp_q, cnt_q};
    tr_raddr  = TrAw'(top_q - TopW'(1));
  end
  rlnp_ram #(.Width(TrW), .Depth(TrailDepth)) u_trail (
    .clk_i, .we_i(tr_we), .waddr_i(tr_waddr), .wdata_i(tr_wdata),
    .raddr_i(tr_raddr), .rdata_o(tr_rdata)
  );

  // level of the entry below the top, tracked in a small level memory
  logic [15:0] lvl_rd;
  logic [TrAw-1:0] lvl_raddr;
  assign lvl_raddr = TrAw'(top_q - TopW'(2));
  rlnp_ram #(.Width(16), .Depth(TrailDepth)) u_level (
    .clk_i, .we_i(tr_we), .waddr_i(tr_waddr), .wdata_i(w_q.search_level),
    .raddr_i(lvl_raddr), .rdata_o(lvl_rd)
  );

  // multiply: coefficient by 33-bit operands, narrow products sign-extended
  // add takes its coefficient from the word, the rest from the table
  logic signed [CoeffBits-1:0]  coeff_v;
  logic signed [32:0]           va_x, vb_x, vc_x;
  logic signed [32:0]           opnd, opnd2;
  logic signed [CoeffBits+32:0] prod_n, prod1_n, prod2_n;
  logic signed [63:0]           prod, prod1, prod2;
  logic                         cpos;
  always_comb begin
    coeff_v = (w_q.operation == OP_ADD) ? signed'(w_q.value_c[CoeffBits-1:0])
                                        : signed'(coeff_rd);
    cpos    = !coeff_v[CoeffBits-1];
    va_x    = {w_q.value_a[31], w_q.value_a};
    vb_x    = {w_q.value_b[31], w_q.value_b};
    vc_x    = {w_q.value_c[31], w_q.value_c};
    opnd    = '0;
    opnd2   = '0;
    case (w_q.operation)
      OP_ADD: begin
        if (w_q.value_a == w_q.value_b) opnd = va_x;
        else opnd = cpos ? va_x : vb_x;
        opnd2 = cpos ? vb_x : va_x;
      end
      OP_INST: begin
        opnd  = cpos ? vb_x : vc_x;
        opnd2 = cpos ? vc_x : vb_x;
      end
      OP_MIN, OP_MAX: opnd = 33'(w_q.value_a) - 33'(w_q.value_b);
      default: opnd = '0;
    endcase
    prod_n  = coeff_v * va_x;
    prod1_n = coeff_v * opnd;
    prod2_n = coeff_v * opnd2;
    prod    = 64'(prod_n);
    prod1   = 64'(prod1_n);
    prod2   = 64'(prod2_n);
  end

  // update
  logic [63:0] fixed_d, minp_d, maxp_d;
  logic [CntW-1:0] cnt_d;
  logic [TopW-1:0] top_d;
  always_comb begin
    fixed_d = fixed_q; minp_d = minp_q; maxp_d = maxp_q; cnt_d = cnt_q; top_d = top_q;
    if (ctrl_i.exec) begin
      case (w_q.operation)
        OP_CLEAR: begin
          fixed_d = '0; minp_d = '0; maxp_d = '0; cnt_d = '0; top_d = '0;
        end
        OP_ADD: if (ok) begin
          if (w_q.value_a == w_q.value_b) fixed_d = fixed_q + prod1;
          else begin
            if (cnt_q < CntW'(MaxVars)) cnt_d = cnt_q + CntW'(1);
            minp_d = minp_q + prod1;
            maxp_d = maxp_q + prod2;
          end
        end
        OP_INST: if (ok) begin
          fixed_d = fixed_q + prod;
          minp_d  = minp_q - prod1;
          maxp_d  = maxp_q - prod2;
          if (cnt_q != '0) cnt_d = cnt_q - CntW'(1);
        end
        OP_MIN, OP_MAX: if (ok) begin
          if ((w_q.operation == OP_MIN) == cpos) minp_d = minp_q + prod1;
          else maxp_d = maxp_q + prod1;
        end
        default: ;
      endcase
      if (tr_we) top_d = top_q + TopW'(1);
    end
    if (ctrl_i.pop_apply) begin
      cnt_d   = tr_rdata[CntW-1:0];
      maxp_d  = tr_rdata[CntW +: 64];
      minp_d  = tr_rdata[CntW + 64 +: 64];
      fixed_d = tr_rdata[CntW + 128 +: 64];
      top_d   = top_q - TopW'(1);
    end
  end

  // bounds check on current state
  logic signed [63:0] lo, hi, tgt;
  logic pinned, outside;
  logic [1:0] b_eff;
  out_word_t res_d;
  always_comb begin
    lo      = signed'(fixed_q + minp_q);
    hi      = signed'(fixed_q + maxp_q);
    tgt     = 64'(target_q);
    pinned  = (lo == tgt) && (hi == tgt);
    outside = (tgt < lo) || (tgt > hi);
    b_eff   = w_q.b_status;
    if (w_q.operation == OP_ASSIGN) b_eff = (w_q.value_a == 32'sd1) ? BTrue : BFalse;
    res_d = '0;
    res_d.trail_overflow = ovf_q;
    if (b_eff == BTrue) res_d.conflict = pinned;
    else if (b_eff == BFalse) res_d.conflict = outside;
    else if (outside) res_d.infer_b = InferTrue;
    else if (pinned) res_d.infer_b = InferFalse;
    if (w_q.operation == OP_ASSIGN) res_d.infer_b = InferNone;
    if (w_q.operation == OP_REWIND || w_q.operation == OP_NONE) res_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      fixed_q  <= '0;
      minp_q   <= '0;
      maxp_q   <= '0;
      cnt_q    <= '0;
      top_q    <= '0;
      ovf_q    <= 1'b0;
      res_o    <= '0;
    end else begin
      if (cfg_we_i) target_q <= cfg_wdata_i;
      fixed_q <= fixed_d;
      minp_q  <= minp_d;
      maxp_q  <= maxp_d;
      cnt_q   <= cnt_d;
      top_q   <= top_d;
      if (ctrl_i.exec) ovf_q <= push_req && !push_skip && push_full;
      if (ctrl_i.emit) res_o <= res_d;
    end
  end

  // input word capture and level tracking for the top entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) w_q <= in_i;
    if (tr_we) top_level_q <= w_q.search_level;
    else if (ctrl_i.pop_apply) top_level_q <= pop_level_q;
    if (ctrl_i.pop_rd) pop_level_q <= lvl_rd;
  end

  always_comb begin
    stat_o.is_rewind   = (w_q.operation == OP_REWIND);
    stat_o.pop_more    = (top_q != '0) && (top_level_q > w_q.search_level);
  end

endmodule

[hw/rtl/rlnp_ctrl.sv]
// ----------------------------------------------------------------------------
// rlnp_ctrl
// sequencer: capture, coefficient read, execute, rewind pops, result hand-off
// ----------------------------------------------------------------------------
module rlnp_ctrl import rlnp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_POPCHK, S_POPRD, S_POPAPPLY, S_EMIT
  } state_e;

  state_e state_q;
  logic   ovalid_q, ovalid_d;

  // the output register frees once taken; a new word may start meanwhile
  logic out_free;
  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.capture   = (state_q == S_IDLE) && in_valid_i;
    ctrl_o.exec      = (state_q == S_EXEC);
    ctrl_o.pop_rd    = (state_q == S_POPRD);
    ctrl_o.pop_apply = (state_q == S_POPAPPLY);
    ctrl_o.emit      = (state_q == S_EMIT) && out_free;
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    if (ctrl_o.emit) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      case (state_q)
        S_IDLE:     if (in_valid_i) state_q <= S_READ;
        S_READ:     state_q <= stat_i.is_rewind ? S_POPCHK : S_EXEC;
        S_EXEC:     state_q <= S_EMIT;
        S_POPCHK:   state_q <= stat_i.pop_more ? S_POPRD : S_EMIT;
        S_POPRD:    state_q <= S_POPAPPLY;
        S_POPAPPLY: state_q <= S_POPCHK;
        S_EMIT:     if (out_free) state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/reified_linear_ne_propagator.sv]
// ----------------------------------------------------------------------------
// reified_linear_ne_propagator
// bounds propagator for b <-> (sum c_i*x_i != target_sum)
// ----------------------------------------------------------------------------
// path: an accepted word passes the read, execute and emit states, all but rewind
// rewind: read, then a pop check, read and apply per trail entry popped, then emit (pop loop on the trail ram port)
// input: a new word is taken only in idle, once the last word has left its emit step
// a result still held by the receiver stalls the next word at its emit step
// reset: sums, count and trail pointer cleared, tables undefined until written
// ----------------------------------------------------------------------------
module reified_linear_ne_propagator import rlnp_pkg::*; #(
  parameter int unsigned MaxVars    = MaxVarsDef,
  parameter int unsigned TrailDepth = TrailDepthDef,
  parameter int unsigned CoeffBits  = CoeffBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: target sum
  input  logic               cfg_we_i,
  input  logic signed [31:0] cfg_wdata_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_data_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_data_o
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  rlnp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  // state, tables and check logic
  rlnp_datapath #(
    .MaxVars(MaxVars), .TrailDepth(TrailDepth), .CoeffBits(CoeffBits)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .in_i(in_data_i),
    .ctrl_i(ctrl), .stat_o(stat),
    .res_o(out_data_o)
  );

endmodule
